// ----- hw/rtl/lkvc_pkg.sv -----
// Package for the LRU key-value cache: field widths, codes, reset values and
// the command/status structs between controller and datapath.
// No dependencies.
package lkvc_pkg;

	// Default number of entries
	localparam int CAPACITY_DEF = 8;

	// Field widths
	localparam int CFG_W      = 4;
	localparam int KEY_W      = 32;
	localparam int VAL_W      = 32;
	localparam int IN_DATA_W  = KEY_W + VAL_W;
	localparam int IN_USER_W  = 1;
	localparam int OUT_DATA_W = 72;

	// Capacity register reset value
	localparam logic [CFG_W-1:0] CAP_RESET = 4'd8;

	// Value returned by a get that misses
	localparam logic [VAL_W-1:0] MISS_VALUE = 32'hFFFF_FFFF;

	// Request kinds
	localparam logic ACT_GET = 1'b0;
	localparam logic ACT_SET = 1'b1;

	// Controller -> datapath commands
	typedef struct packed {
		logic load;      // capture request, restart index
		logic scan;      // lookup pass: read entry and rank at index
		logic update;    // rank pass: read rank at index, write back next cycle
		logic clr_idx;   // restart index between passes
		logic commit;    // write entry, valid, occupancy and load result
	} lkvc_cmd_t;

	// Datapath -> controller status
	typedef struct packed {
		logic idx_last;  // index points at the last entry
		logic out_free;  // result register can take a new result
	} lkvc_sts_t;

endpackage

// ----- hw/rtl/lkvc_ram.sv -----
// Generic simple dual-port RAM, one write and one registered read per cycle.
// No dependencies.
module lkvc_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 8
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port and registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ----- hw/rtl/lkvc_ctrl.sv -----
// Controller of the LRU key-value cache: sequences the lookup pass, the rank
// update pass and the commit. Depends on lkvc_pkg.
module lkvc_ctrl import lkvc_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      s_tvalid,
	output logic      s_tready,
	input  lkvc_sts_t sts,
	output lkvc_cmd_t cmd
);

	typedef enum logic [5:0] {
		ST_IDLE     = 6'b000001,
		ST_SCAN     = 6'b000010,
		ST_SCAN_END = 6'b000100,
		ST_UPDATE   = 6'b001000,
		ST_UPD_END  = 6'b010000,
		ST_COMMIT   = 6'b100000
	} state_t;

	state_t state_q, state_d;

	// next state and commands
	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (s_tvalid) begin
					cmd.load = 1'b1;
					state_d  = ST_SCAN;
				end
			end
			ST_SCAN: begin
				cmd.scan = 1'b1;
				if (sts.idx_last) begin
					state_d = ST_SCAN_END;
				end
			end
			ST_SCAN_END: begin
				// last lookup read lands this cycle
				cmd.clr_idx = 1'b1;
				state_d     = ST_UPDATE;
			end
			ST_UPDATE: begin
				cmd.update = 1'b1;
				if (sts.idx_last) begin
					state_d = ST_UPD_END;
				end
			end
			ST_UPD_END: begin
				// last rank write-back this cycle
				state_d = ST_COMMIT;
			end
			ST_COMMIT: begin
				if (sts.out_free) begin
					cmd.commit = 1'b1;
					state_d    = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	assign s_tready = (state_q == ST_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

// ----- hw/rtl/lkvc_dp.sv -----
// Datapath of the LRU key-value cache: entry and rank RAMs, valid bits,
// occupancy, capacity register, lookup results and the result register.
// Depends on lkvc_pkg and lkvc_ram.
module lkvc_dp import lkvc_pkg::*; #(
	parameter int CAPACITY = CAPACITY_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  lkvc_cmd_t                           cmd,
	output lkvc_sts_t                           sts,
	input  logic                                in_action,
	input  logic [KEY_W-1:0]                    in_key,
	input  logic [VAL_W-1:0]                    in_value,
	input  logic                                cfg_we,
	input  logic [CFG_W-1:0]                    cfg_wdata,
	input  logic                                m_tready,
	output logic                                m_tvalid,
	output logic [OUT_DATA_W-1:0]               m_tdata,
	output logic [CAPACITY-1:0]                 valid_bits,
	output logic [$clog2(CAPACITY+1)-1:0]       occupancy
);

	localparam int IW    = $clog2(CAPACITY);
	localparam int OW    = $clog2(CAPACITY + 1);
	localparam int CMP_W = (OW > CFG_W) ? OW : CFG_W;
	localparam int ENT_W = KEY_W + VAL_W;
	localparam int PAD_W = OUT_DATA_W - (2 + KEY_W + VAL_W);

	localparam logic [IW-1:0]    LAST_IDX = IW'(CAPACITY - 1);
	localparam logic [CMP_W-1:0] CAP_MAX  = CMP_W'(CAPACITY);

	// request and configuration
	logic                req_action_q;
	logic [KEY_W-1:0]    req_key_q;
	logic [VAL_W-1:0]    req_value_q;
	logic [CFG_W-1:0]    cap_q;

	// sequencing
	logic [IW-1:0]       idx_q;
	logic [IW-1:0]       idx_s1;
	logic                scan_s1;
	logic                upd_s1;

	// store state
	logic [CAPACITY-1:0] valid_q;
	logic [OW-1:0]       occ_q;

	// lookup pass results
	logic                hit_q;
	logic [IW-1:0]       hit_idx_q;
	logic [IW-1:0]       hit_rank_q;
	logic [VAL_W-1:0]    hit_val_q;
	logic                free_q;
	logic [IW-1:0]       free_idx_q;
	logic [IW-1:0]       lru_idx_q;
	logic [KEY_W-1:0]    lru_key_q;

	// result register
	logic                  out_valid_q;
	logic [OUT_DATA_W-1:0] out_data_q;

	// RAM ports
	logic [ENT_W-1:0]    ent_rdata;
	logic [IW-1:0]       rank_rdata;
	logic                ent_we;
	logic [IW-1:0]       rank_wdata;

	// derived
	logic [KEY_W-1:0]    ent_key;
	logic [VAL_W-1:0]    ent_val;
	logic [CMP_W-1:0]    cap_ext;
	logic [CMP_W-1:0]    eff_cap;
	logic                evict;
	logic [IW-1:0]       target;
	logic [OW-1:0]       occ_m1;
	logic [OW-1:0]       thresh;
	logic                rank_inc;
	logic [VAL_W-1:0]    read_value;
	logic [KEY_W-1:0]    evicted_key;

	assign ent_key = ent_rdata[KEY_W-1:0];
	assign ent_val = ent_rdata[ENT_W-1:KEY_W];

	// effective capacity: zero acts as one, clipped to CAPACITY
	assign cap_ext = CMP_W'(cap_q);
	always_comb begin
		priority if (cap_q == '0) begin
			eff_cap = CMP_W'(1);
		end else if (cap_ext > CAP_MAX) begin
			eff_cap = CAP_MAX;
		end else begin
			eff_cap = cap_ext;
		end
	end

	// decision after the lookup pass
	assign evict  = !hit_q && (CMP_W'(occ_q) >= eff_cap);
	assign occ_m1 = occ_q - OW'(1);
	always_comb begin
		priority if (hit_q) begin
			target = hit_idx_q;
		end else if (evict) begin
			target = lru_idx_q;
		end else begin
			target = free_idx_q;
		end
	end
	// entries more recent than this rank age by one
	assign thresh = hit_q ? OW'(hit_rank_q) : occ_q;

	// rank write-back
	assign rank_inc = valid_q[idx_s1] && (idx_s1 != target) && (OW'(rank_rdata) < thresh);
	always_comb begin
		priority if (idx_s1 == target) begin
			rank_wdata = '0;
		end else if (rank_inc) begin
			rank_wdata = rank_rdata + IW'(1);
		end else begin
			rank_wdata = rank_rdata;
		end
	end

	// entry write on miss or on set
	assign ent_we = cmd.commit && (!hit_q || (req_action_q == ACT_SET));

	lkvc_ram #(
		.WIDTH (ENT_W),
		.DEPTH (CAPACITY)
	) u_ent_ram (
		.clk   (clk),
		.we    (ent_we),
		.waddr (target),
		.wdata ({req_value_q, req_key_q}),
		.raddr (idx_q),
		.rdata (ent_rdata)
	);

	lkvc_ram #(
		.WIDTH (IW),
		.DEPTH (CAPACITY)
	) u_rank_ram (
		.clk   (clk),
		.we    (upd_s1),
		.waddr (idx_s1),
		.wdata (rank_wdata),
		.raddr (idx_q),
		.rdata (rank_rdata)
	);

	// request capture
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			req_action_q <= in_action;
			req_key_q    <= in_key;
			req_value_q  <= in_value;
		end
	end

	// capacity register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= CAP_RESET;
		end else if (cfg_we) begin
			cap_q <= cfg_wdata;
		end
	end

	// index counter and read pipeline
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q   <= '0;
			scan_s1 <= 1'b0;
			upd_s1  <= 1'b0;
		end else begin
			scan_s1 <= cmd.scan;
			upd_s1  <= cmd.update;
			if (cmd.load || cmd.clr_idx) begin
				idx_q <= '0;
			end else if (cmd.scan || cmd.update) begin
				idx_q <= idx_q + IW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		idx_s1 <= idx_q;
	end

	// lookup pass flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hit_q  <= 1'b0;
			free_q <= 1'b0;
		end else if (cmd.load) begin
			hit_q  <= 1'b0;
			free_q <= 1'b0;
		end else if (scan_s1) begin
			if (valid_q[idx_s1] && (ent_key == req_key_q)) begin
				hit_q <= 1'b1;
			end
			if (!valid_q[idx_s1]) begin
				free_q <= 1'b1;
			end
		end
	end

	// lookup pass payload: first hit, first free slot, least recent entry
	always_ff @(posedge clk) begin
		if (scan_s1) begin
			if (valid_q[idx_s1] && (ent_key == req_key_q) && !hit_q) begin
				hit_idx_q  <= idx_s1;
				hit_rank_q <= rank_rdata;
				hit_val_q  <= ent_val;
			end
			if (!valid_q[idx_s1] && !free_q) begin
				free_idx_q <= idx_s1;
			end
			if (valid_q[idx_s1] && (OW'(rank_rdata) == occ_m1)) begin
				lru_idx_q <= idx_s1;
				lru_key_q <= ent_key;
			end
		end
	end

	// valid bits and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			occ_q   <= '0;
		end else if (cmd.commit && !hit_q) begin
			valid_q[target] <= 1'b1;
			if (!evict) begin
				occ_q <= occ_q + OW'(1);
			end
		end
	end

	// result fields
	always_comb begin
		priority if (req_action_q == ACT_SET) begin
			read_value = req_value_q;
		end else if (hit_q) begin
			read_value = hit_val_q;
		end else begin
			read_value = MISS_VALUE;
		end
	end
	assign evicted_key = evict ? lru_key_q : '0;

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.commit) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			out_data_q <= {{PAD_W{1'b0}}, evicted_key, evict, read_value, hit_q};
		end
	end

	assign m_tvalid     = out_valid_q;
	assign m_tdata      = out_data_q;
	assign sts.idx_last = (idx_q == LAST_IDX);
	assign sts.out_free = !out_valid_q || m_tready;
	assign valid_bits   = valid_q;
	assign occupancy    = occ_q;

endmodule

// ----- hw/rtl/lru_key_value_cache.sv -----
// Top level of the LRU key-value cache: controller plus datapath.
// Depends on lkvc_pkg, lkvc_ctrl and lkvc_dp (which holds lkvc_ram).

// Fully associative key-value cache of CAPACITY entries with least-recently-used
// replacement. Each request (get or set) gives exactly one result. A request is
// taken only when the block is idle; it then walks the entry RAM once to look up
// the key and find the free and least recent slots, and walks the recency RAM
// once more to age the ranks, so a new request is taken only after the last one
// has committed; both walks go through the single read port of those RAMs.
// A finished result sits in an output register, so a stalled result side only
// holds up the commit of the next request. The store is empty after reset; no
// clearing pass is needed. Write capacity_in_use only while no request is open.
module lru_key_value_cache import lkvc_pkg::*; #(
	parameter int CAPACITY = CAPACITY_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	// request channel
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [IN_DATA_W-1:0]  s_tdata,   // [31:0] key, [63:32] value
	input  logic [IN_USER_W-1:0]  s_tuser,   // [0] action (0 get, 1 set)
	// result channel
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [OUT_DATA_W-1:0] m_tdata,   // [0] found, [32:1] read_value,
	                                         // [33] evicted, [65:34] evicted_key,
	                                         // [71:66] zero
	// capacity_in_use register
	input  logic                  cfg_we,
	input  logic [CFG_W-1:0]      cfg_wdata
);

	localparam int OW = $clog2(CAPACITY + 1);

	lkvc_cmd_t           cmd;
	lkvc_sts_t           sts;
	logic [CAPACITY-1:0] valid_bits;
	logic [OW-1:0]       occupancy;

	lkvc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	lkvc_dp #(
		.CAPACITY (CAPACITY)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.sts        (sts),
		.in_action  (s_tuser[0]),
		.in_key     (s_tdata[KEY_W-1:0]),
		.in_value   (s_tdata[IN_DATA_W-1:KEY_W]),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata),
		.m_tready   (m_tready),
		.m_tvalid   (m_tvalid),
		.m_tdata    (m_tdata),
		.valid_bits (valid_bits),
		.occupancy  (occupancy)
	);

	// occupancy tracks the number of valid entries
	a_occ_matches_valid: assert property (@(posedge clk) disable iff (!arst_n)
		$countones(valid_bits) == int'(occupancy))
		else $error("occupancy does not match valid entries");

	// occupancy never exceeds the store size
	a_occ_bound: assert property (@(posedge clk) disable iff (!arst_n)
		int'(occupancy) <= CAPACITY)
		else $error("occupancy above capacity");

	// a taken request keeps the block busy the next cycle
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("request accepted on back-to-back cycles");

endmodule
